// File: rtl/fsop_pkg.sv
// ----------------------------------------------------------------------------
// Frame slot ownership pool package
// Opcodes, owner codes and the per-slot metadata word shared by the pool RTL.
// ----------------------------------------------------------------------------
package fsop_pkg;

    localparam int unsigned OpcodeW = 3;
    localparam int unsigned SlotW   = 6;
    localparam int unsigned WordW   = 32;
    localparam int unsigned StampW  = 64;

    typedef enum logic [OpcodeW-1:0] {
        OP_ACQ_DMA  = 3'd0,
        OP_COMPLETE = 3'd1,
        OP_ACQ_TX   = 3'd2,
        OP_RELEASE  = 3'd3,
        OP_CANCEL   = 3'd4,
        OP_DROP     = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        OWN_FREE  = 2'd0,
        OWN_DMA   = 2'd1,
        OWN_READY = 2'd2,
        OWN_TX    = 2'd3
    } owner_t;

    // Metadata held per slot in the metadata memory.
    typedef struct packed {
        logic [WordW-1:0]  generation;
        logic [StampW-1:0] timestamp;
        logic [WordW-1:0]  status;
        logic [WordW-1:0]  frame_num;
    } meta_t;

endpackage

// File: rtl/fsop_if.sv
// ----------------------------------------------------------------------------
// Frame slot ownership pool channels
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface fsop_req_if;
    logic                        valid;
    logic                        ready;
    logic [fsop_pkg::OpcodeW-1:0] opcode;
    logic [fsop_pkg::SlotW-1:0]   slot_index;
    logic [fsop_pkg::WordW-1:0]   frame_num;
    logic [fsop_pkg::WordW-1:0]   dma_status;
    logic [fsop_pkg::StampW-1:0]  capture_ts;

    modport source (
        output valid, opcode, slot_index, frame_num, dma_status, capture_ts,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot_index, frame_num, dma_status, capture_ts,
        output ready
    );
endinterface

interface fsop_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [fsop_pkg::SlotW-1:0]   slot_out;
    logic [fsop_pkg::WordW-1:0]   frame_id_out;
    logic [fsop_pkg::WordW-1:0]   status_out;
    logic [fsop_pkg::StampW-1:0]  timestamp_out;
    logic [fsop_pkg::WordW-1:0]   generation_out;
    logic [fsop_pkg::WordW-1:0]   dropped_total;

    modport source (
        output valid, ok, slot_out, frame_id_out, status_out, timestamp_out,
               generation_out, dropped_total,
        input  ready
    );
    modport sink (
        input  valid, ok, slot_out, frame_id_out, status_out, timestamp_out,
               generation_out, dropped_total,
        output ready
    );
endinterface

// File: rtl/fsop_meta_ram.sv
// ----------------------------------------------------------------------------
// Frame slot metadata memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsop_meta_ram #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  fsop_pkg::meta_t          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output fsop_pkg::meta_t          rdata
);

    fsop_pkg::meta_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/frame_slot_ownership_pool.sv
// ----------------------------------------------------------------------------
// Frame slot ownership pool
// Hands frame slots between a DMA producer and a transmit consumer and passes
// only the newest completed frame to transmit.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Transfer moves
//  --------+-----+-----------------------------------------------------------
//  req     | in  | opcode, slot_index, frame_num, dma_status, capture_ts
//  rsp     | out | ok, slot_out, frame_id_out, status_out, timestamp_out,
//          |     | generation_out, dropped_total
//
// One operation is worked on at a time. Acquire_dma, drop_ready and
// acquire_latest_tx scan over the slots, one slot per cycle; acquire_latest_tx
// reads each slot through the metadata memory read port.
// Reset puts every slot in the free state, the generation counter to one and
// the drop counter to zero. The response register holds a finished result while
// the next request is taken; only a second result waits on a stalled rsp.
// ----------------------------------------------------------------------------
module frame_slot_ownership_pool #(
    parameter int unsigned SLOT_COUNT = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    fsop_req_if.sink      req,
    fsop_rsp_if.source    rsp
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ACQ_SCAN,
        S_DROP_SCAN,
        S_LT_SCAN,
        S_LT_TAIL,
        S_LT_FETCH,
        S_LT_OUT,
        S_FINISH
    } state_t;

    // Sequencer state.
    state_t                        state_reg, state_next;
    logic [fsop_pkg::OpcodeW-1:0]  op_reg, op_next;
    logic [fsop_pkg::SlotW-1:0]    idx_reg, idx_next;
    logic [fsop_pkg::WordW-1:0]    fid_reg, fid_next;
    logic [fsop_pkg::WordW-1:0]    stw_reg, stw_next;
    logic [fsop_pkg::StampW-1:0]   ts_reg, ts_next;
    logic [IDX_W-1:0]              cnt_reg, cnt_next;

    // Pool state kept outside the metadata memory.
    fsop_pkg::owner_t              owner_reg [SLOT_COUNT];
    logic [fsop_pkg::WordW-1:0]    next_gen_reg, next_gen_next;
    logic [fsop_pkg::WordW-1:0]    drop_reg, drop_next;

    // Newest-frame search.
    logic                          found_reg, found_next;
    logic [IDX_W-1:0]              best_reg, best_next;
    logic [fsop_pkg::WordW-1:0]    best_gen_reg, best_gen_next;
    logic                          pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]              pipe_idx_reg, pipe_idx_next;
    logic [fsop_pkg::WordW-1:0]    gen_diff;

    // Result of the operation in progress.
    logic                          res_ok_reg, res_ok_next;
    logic [fsop_pkg::SlotW-1:0]    res_slot_reg, res_slot_next;
    fsop_pkg::meta_t               res_meta_reg, res_meta_next;

    // Response register.
    logic                          out_vld_reg, out_vld_next;
    logic                          out_ok_reg, out_ok_next;
    logic [fsop_pkg::SlotW-1:0]    out_slot_reg, out_slot_next;
    fsop_pkg::meta_t               out_meta_reg, out_meta_next;
    logic [fsop_pkg::WordW-1:0]    out_drop_reg, out_drop_next;

    // Owner table write port.
    logic                          own_we;
    logic [IDX_W-1:0]              own_wa;
    fsop_pkg::owner_t              own_wd;

    // Metadata memory ports.
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_raddr;
    fsop_pkg::meta_t               ram_wdata;
    fsop_pkg::meta_t               ram_rdata;

    logic                          idx_ok;
    logic [IDX_W-1:0]              idx_sel;
    fsop_pkg::owner_t              idx_own;
    fsop_pkg::owner_t              cnt_own;
    logic                          cnt_last;

    fsop_meta_ram #(
        .DEPTH (SLOT_COUNT)
    ) u_meta_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_sel),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The slot index is checked against the pool size before it addresses
    // the owner table; bits above the table index are covered by that check.
    assign idx_ok   = {1'b0, idx_reg} < (fsop_pkg::SlotW + 1)'(SLOT_COUNT);
    assign idx_sel  = idx_reg[IDX_W-1:0];
    assign idx_own  = owner_reg[idx_sel];
    assign cnt_own  = owner_reg[cnt_reg];
    assign cnt_last = (cnt_reg == LAST_IDX);

    // Wrapped generation difference of the slot just read against the best.
    assign gen_diff = ram_rdata.generation - best_gen_reg;

    assign ram_wdata = '{generation: next_gen_reg, timestamp: ts_reg,
                         status: stw_reg, frame_num: fid_reg};

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid          = out_vld_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.slot_out       = out_slot_reg;
    assign rsp.frame_id_out   = out_meta_reg.frame_num;
    assign rsp.status_out     = out_meta_reg.status;
    assign rsp.timestamp_out  = out_meta_reg.timestamp;
    assign rsp.generation_out = out_meta_reg.generation;
    assign rsp.dropped_total  = out_drop_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        fid_next      = fid_reg;
        stw_next      = stw_reg;
        ts_next       = ts_reg;
        cnt_next      = cnt_reg;
        next_gen_next = next_gen_reg;
        drop_next     = drop_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_gen_next = best_gen_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = cnt_reg;
        res_ok_next   = res_ok_reg;
        res_slot_next = res_slot_reg;
        res_meta_next = res_meta_reg;
        out_vld_next  = out_vld_reg;
        out_ok_next   = out_ok_reg;
        out_slot_next = out_slot_reg;
        out_meta_next = out_meta_reg;
        out_drop_next = out_drop_reg;
        own_we        = 1'b0;
        own_wa        = cnt_reg;
        own_wd        = fsop_pkg::OWN_FREE;
        ram_we        = 1'b0;
        ram_raddr     = cnt_reg;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = req.opcode;
                    idx_next      = req.slot_index;
                    fid_next      = req.frame_num;
                    stw_next      = req.dma_status;
                    ts_next       = req.capture_ts;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                    res_meta_next = '0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FINISH;
                case (fsop_pkg::opcode_t'(op_reg))
                    fsop_pkg::OP_ACQ_DMA:
                    begin
                        state_next = S_ACQ_SCAN;
                    end
                    fsop_pkg::OP_COMPLETE:
                    begin
                        if (idx_ok && (fid_reg != '0) && (idx_own == fsop_pkg::OWN_DMA))
                        begin
                            ram_we      = 1'b1;
                            own_we      = 1'b1;
                            own_wa      = idx_sel;
                            own_wd      = fsop_pkg::OWN_READY;
                            res_ok_next = 1'b1;
                            // The generation counter skips zero on wrap.
                            next_gen_next = next_gen_reg + 32'd1;
                            if (next_gen_next == '0)
                            begin
                                next_gen_next = 32'd1;
                            end
                        end
                    end
                    fsop_pkg::OP_ACQ_TX:
                    begin
                        state_next = S_LT_SCAN;
                    end
                    fsop_pkg::OP_RELEASE:
                    begin
                        if (idx_ok && (idx_own == fsop_pkg::OWN_TX))
                        begin
                            own_we      = 1'b1;
                            own_wa      = idx_sel;
                            res_ok_next = 1'b1;
                        end
                    end
                    fsop_pkg::OP_CANCEL:
                    begin
                        if (idx_ok && (idx_own == fsop_pkg::OWN_DMA))
                        begin
                            own_we      = 1'b1;
                            own_wa      = idx_sel;
                            res_ok_next = 1'b1;
                        end
                    end
                    fsop_pkg::OP_DROP:
                    begin
                        res_ok_next = 1'b1;
                        state_next  = S_DROP_SCAN;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_ACQ_SCAN:
            begin
                if (cnt_own == fsop_pkg::OWN_FREE)
                begin
                    own_we        = 1'b1;
                    own_wd        = fsop_pkg::OWN_DMA;
                    res_ok_next   = 1'b1;
                    res_slot_next = fsop_pkg::SlotW'(cnt_reg);
                    state_next    = S_FINISH;
                end
                else if (cnt_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DROP_SCAN:
            begin
                if (cnt_own == fsop_pkg::OWN_READY)
                begin
                    own_we    = 1'b1;
                    drop_next = drop_reg + 32'd1;
                end
                if (cnt_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_LT_SCAN:
            begin
                // Generation read issued here, compared in the following cycle.
                pipe_vld_next = (cnt_own == fsop_pkg::OWN_READY);
                if (cnt_last)
                begin
                    state_next = S_LT_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_LT_TAIL:
            begin
                state_next = S_LT_FETCH;
            end

            S_LT_FETCH:
            begin
                ram_raddr  = best_reg;
                state_next = found_reg ? S_LT_OUT : S_FINISH;
            end

            S_LT_OUT:
            begin
                own_we        = 1'b1;
                own_wa        = best_reg;
                own_wd        = fsop_pkg::OWN_TX;
                res_ok_next   = 1'b1;
                res_slot_next = fsop_pkg::SlotW'(best_reg);
                res_meta_next = ram_rdata;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next  = 1'b1;
                    out_ok_next   = res_ok_reg;
                    out_slot_next = res_slot_reg;
                    out_meta_next = res_meta_reg;
                    out_drop_next = drop_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Compare stage of the newest-frame search. A ready slot that loses,
        // or a best that is displaced, can never win later, so it is freed
        // and counted as dropped right away.
        if (pipe_vld_reg)
        begin
            if (!found_reg)
            begin
                found_next    = 1'b1;
                best_next     = pipe_idx_reg;
                best_gen_next = ram_rdata.generation;
            end
            else
            begin
                own_we    = 1'b1;
                drop_next = drop_reg + 32'd1;
                if ((gen_diff != '0) && !gen_diff[fsop_pkg::WordW-1])
                begin
                    own_wa        = best_reg;
                    best_next     = pipe_idx_reg;
                    best_gen_next = ram_rdata.generation;
                end
                else
                begin
                    own_wa = pipe_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            idx_reg      <= '0;
            fid_reg      <= '0;
            stw_reg      <= '0;
            ts_reg       <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owner_reg[i] <= fsop_pkg::OWN_FREE;
            end
            next_gen_reg <= 32'd1;
            drop_reg     <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_gen_reg <= '0;
            pipe_vld_reg <= 1'b0;
            pipe_idx_reg <= '0;
            res_ok_reg   <= 1'b0;
            res_slot_reg <= '0;
            res_meta_reg <= '0;
            out_vld_reg  <= 1'b0;
            out_ok_reg   <= 1'b0;
            out_slot_reg <= '0;
            out_meta_reg <= '0;
            out_drop_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            idx_reg      <= idx_next;
            fid_reg      <= fid_next;
            stw_reg      <= stw_next;
            ts_reg       <= ts_next;
            cnt_reg      <= cnt_next;
            if (own_we)
            begin
                owner_reg[own_wa] <= own_wd;
            end
            next_gen_reg <= next_gen_next;
            drop_reg     <= drop_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            best_gen_reg <= best_gen_next;
            pipe_vld_reg <= pipe_vld_next;
            pipe_idx_reg <= pipe_idx_next;
            res_ok_reg   <= res_ok_next;
            res_slot_reg <= res_slot_next;
            res_meta_reg <= res_meta_next;
            out_vld_reg  <= out_vld_next;
            out_ok_reg   <= out_ok_next;
            out_slot_reg <= out_slot_next;
            out_meta_reg <= out_meta_next;
            out_drop_reg <= out_drop_next;
        end
    end

    // The generation counter never holds zero.
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_gen_reg != '0)
        else $error("generation counter reached zero");

    // The drop counter only ever advances by one per cycle.
    a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (drop_reg != $past(drop_reg)) |-> (drop_reg == $past(drop_reg) + 32'd1))
        else $error("drop counter jumped");

    // Compare stage is only busy while the generation scan drains.
    a_pipe_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg |-> ((state_reg == S_LT_SCAN) || (state_reg == S_LT_TAIL)))
        else $error("compare stage active outside the scan");

    // The chosen slot is owned by transmit once handed out.
    a_tx_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LT_OUT) |=> (owner_reg[$past(best_reg)] == fsop_pkg::OWN_TX))
        else $error("chosen slot not owned by transmit");

endmodule
